// ===== hw/rtl/tss_pkg.sv =====
// Shared types and constants for the triangle scanline span pipeline.
`timescale 1ns / 1ps
`default_nettype none
package tss_pkg;

   // Image side in pixels; rows and span ends are limited to it.
   localparam int ImageSize = 4096;
   localparam int CoordW    = 12;
   // Number of quotient bits, one per divider stage.
   localparam int DivSteps  = CoordW;

   typedef logic [CoordW-1:0] coord_type;

   // Operands of one interpolation before the multiply.
   typedef struct packed {
      coord_type mag;   // magnitude of the edge delta in x
      coord_type num;   // rows into the edge
      coord_type den;   // edge height
   } lane_type;

   // Partial state of one long division.
   typedef struct packed {
      coord_type den;
      coord_type rem;
      coord_type low;   // dividend bits still to be brought down
      coord_type quo;
   } div_type;

   // Per-item data that rides alongside the dividers.
   typedef struct packed {
      logic      drawn;
      coord_type row_y;
      coord_type base_a;
      coord_type base_b;
      logic      neg_a;
      logic      neg_b;
   } side_type;

endpackage
`default_nettype wire

// ===== hw/rtl/tss_setup.sv =====
// First stage: vertex sort, row classification and selection of edge operands.
`timescale 1ns / 1ps
`default_nettype none
module tss_setup (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              in_valid,
   input  wire tss_pkg::coord_type ax,
   input  wire tss_pkg::coord_type ay,
   input  wire tss_pkg::coord_type bx,
   input  wire tss_pkg::coord_type by_coord,
   input  wire tss_pkg::coord_type cx,
   input  wire tss_pkg::coord_type cy,
   input  wire tss_pkg::coord_type row_offset,
   output logic                   out_valid,
   output tss_pkg::lane_type      lane_a,
   output tss_pkg::lane_type      lane_b,
   output tss_pkg::side_type      side
);
   import tss_pkg::*;

   logic     valid_ff;
   lane_type lane_a_ff, lane_a_in;
   lane_type lane_b_ff, lane_b_in;
   side_type side_ff, side_in;

   coord_type vx0, vy0, vx1, vy1, vx2, vy2;
   coord_type sx0, sy0, sx1, sy1, sx2, sy2;
   coord_type tx0, ty0, tx2, ty2;
   coord_type h, h_up, h_dn;
   logic [CoordW:0]   d_long, d_short;
   logic [CoordW:0]   row_sum;
   logic              lower;

   // Three compare-and-swap steps order the vertices by y.
   always_comb begin
      vx0 = ax; vy0 = ay; vx1 = bx; vy1 = by_coord; vx2 = cx; vy2 = cy;
      if (vy0 > vy1) begin
         sx0 = vx1; sy0 = vy1; sx1 = vx0; sy1 = vy0;
      end else begin
         sx0 = vx0; sy0 = vy0; sx1 = vx1; sy1 = vy1;
      end
      if (sy0 > vy2) begin
         tx0 = vx2; ty0 = vy2; tx2 = sx0; ty2 = sy0;
      end else begin
         tx0 = sx0; ty0 = sy0; tx2 = vx2; ty2 = vy2;
      end
      if (sy1 > ty2) begin
         sx2 = sx1; sy2 = sy1; sx1 = tx2; sy1 = ty2;
      end else begin
         sx2 = tx2; sy2 = ty2;
      end
      sx0 = tx0; sy0 = ty0;
   end

   // Heights, row test and the operands of both edges.
   always_comb begin
      h       = sy2 - sy0;
      h_up    = sy1 - sy0;
      h_dn    = sy2 - sy1;
      row_sum = {1'b0, sy0} + {1'b0, row_offset};
      lower   = (row_offset > h_up) || (h_up == '0);
      d_long  = {1'b0, sx2} - {1'b0, sx0};
      if (lower) begin
         d_short = {1'b0, sx2} - {1'b0, sx1};
      end else begin
         d_short = {1'b0, sx1} - {1'b0, sx0};
      end

      side_in.drawn  = (row_offset < h) && (32'(row_sum) < ImageSize);
      side_in.row_y  = row_sum[CoordW-1:0];
      side_in.base_a = sx0;
      side_in.base_b = lower ? sx1 : sx0;
      side_in.neg_a  = d_long[CoordW];
      side_in.neg_b  = d_short[CoordW];

      lane_a_in.mag = d_long[CoordW] ? CoordW'(-d_long) : d_long[CoordW-1:0];
      lane_a_in.num = row_offset;
      lane_a_in.den = h;
      lane_b_in.mag = d_short[CoordW] ? CoordW'(-d_short) : d_short[CoordW-1:0];
      lane_b_in.num = lower ? (row_offset - h_up) : row_offset;
      lane_b_in.den = lower ? h_dn : h_up;
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         lane_a_ff <= lane_a_in;
         lane_b_ff <= lane_b_in;
         side_ff   <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign lane_a    = lane_a_ff;
   assign lane_b    = lane_b_ff;
   assign side      = side_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/tss_mul.sv =====
// Multiply stage: forms the dividends of both edge interpolations.
`timescale 1ns / 1ps
`default_nettype none
module tss_mul (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              in_valid,
   input  wire tss_pkg::lane_type lane_a,
   input  wire tss_pkg::lane_type lane_b,
   input  wire tss_pkg::side_type side_i,
   output logic                   out_valid,
   output tss_pkg::div_type       div_a,
   output tss_pkg::div_type       div_b,
   output tss_pkg::side_type      side_o
);
   import tss_pkg::*;

   logic     valid_ff;
   div_type  div_a_ff, div_a_in;
   div_type  div_b_ff, div_b_in;
   side_type side_ff;
   logic [2*CoordW-1:0] prod_a, prod_b;

   // The upper half of each product is already below the divisor, since the
   // quotient fits in one coordinate.
   always_comb begin
      prod_a       = (2*CoordW)'(lane_a.mag) * (2*CoordW)'(lane_a.num);
      prod_b       = (2*CoordW)'(lane_b.mag) * (2*CoordW)'(lane_b.num);
      div_a_in.den = lane_a.den;
      div_a_in.rem = prod_a[2*CoordW-1:CoordW];
      div_a_in.low = prod_a[CoordW-1:0];
      div_a_in.quo = '0;
      div_b_in.den = lane_b.den;
      div_b_in.rem = prod_b[2*CoordW-1:CoordW];
      div_b_in.low = prod_b[CoordW-1:0];
      div_b_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         div_a_ff <= div_a_in;
         div_b_ff <= div_b_in;
         side_ff  <= side_i;
      end
   end

   assign out_valid = valid_ff;
   assign div_a     = div_a_ff;
   assign div_b     = div_b_ff;
   assign side_o    = side_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/tss_div.sv =====
// Pipelined restoring divider for both edges, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module tss_div (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              in_valid,
   input  wire tss_pkg::div_type  div_a_i,
   input  wire tss_pkg::div_type  div_b_i,
   input  wire tss_pkg::side_type side_i,
   output logic                   out_valid,
   output tss_pkg::div_type       div_a_o,
   output tss_pkg::div_type       div_b_o,
   output tss_pkg::side_type      side_o
);
   import tss_pkg::*;

   logic     valid_ff [DivSteps];
   div_type  div_a_ff [DivSteps];
   div_type  div_b_ff [DivSteps];
   side_type side_ff  [DivSteps];

   // One shift-compare-subtract step of long division.
   function automatic div_type div_step(input div_type d);
      logic [CoordW:0] trial;
      logic            ge;
      div_type         r;
      trial = {d.rem, d.low[CoordW-1]};
      ge    = trial >= {1'b0, d.den};
      r.den = d.den;
      r.rem = ge ? CoordW'(trial - {1'b0, d.den}) : trial[CoordW-1:0];
      r.low = {d.low[CoordW-2:0], 1'b0};
      r.quo = {d.quo[CoordW-2:0], ge};
      return r;
   endfunction

   for (genvar s = 0; s < DivSteps; s++) begin : g_step
      // Each stage takes its predecessor's partial result.
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (enable) begin
            valid_ff[s] <= (s == 0) ? in_valid : valid_ff[(s == 0) ? 0 : s-1];
         end
         if (enable) begin
            if (s == 0) begin
               div_a_ff[s] <= div_step(div_a_i);
               div_b_ff[s] <= div_step(div_b_i);
               side_ff[s]  <= side_i;
            end else begin
               div_a_ff[s] <= div_step(div_a_ff[(s == 0) ? 0 : s-1]);
               div_b_ff[s] <= div_step(div_b_ff[(s == 0) ? 0 : s-1]);
               side_ff[s]  <= side_ff[(s == 0) ? 0 : s-1];
            end
         end
      end
   end

   assign out_valid = valid_ff[DivSteps-1];
   assign div_a_o   = div_a_ff[DivSteps-1];
   assign div_b_o   = div_b_ff[DivSteps-1];
   assign side_o    = side_ff[DivSteps-1];

endmodule
`default_nettype wire

// ===== hw/rtl/tss_finish.sv =====
// Final stage: floor correction, end ordering, clipping and the result register.
`timescale 1ns / 1ps
`default_nettype none
module tss_finish (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              enable,
   input  wire logic              in_valid,
   input  wire tss_pkg::div_type  div_a,
   input  wire tss_pkg::div_type  div_b,
   input  wire tss_pkg::side_type side,
   output logic                   out_valid,
   output logic                   row_inside,
   output tss_pkg::coord_type     row_y,
   output tss_pkg::coord_type     span_left,
   output tss_pkg::coord_type     span_right
);
   import tss_pkg::*;

   localparam int EndW = CoordW + 2;

   logic      valid_ff;
   logic      drawn_ff, drawn_in;
   coord_type row_y_ff, row_y_in;
   coord_type left_ff, left_in;
   coord_type right_ff, right_in;
   logic signed [EndW-1:0] end_a, end_b, lo, hi;

   // A negative delta rounds towards minus infinity: add one when inexact.
   function automatic logic signed [EndW-1:0] edge_end(
      input coord_type base, input logic neg, input div_type d);
      logic [EndW-1:0] mag;
      mag = EndW'(d.quo) + EndW'(d.rem != '0);
      if (neg) begin
         return $signed(EndW'(base)) - $signed(mag);
      end
      return $signed(EndW'(base)) + $signed(EndW'(d.quo));
   endfunction

   function automatic coord_type clip_x(input logic signed [EndW-1:0] v);
      if (v < 0) begin
         return '0;
      end
      if (32'(v) > ImageSize - 1) begin
         return CoordW'(ImageSize - 1);
      end
      return v[CoordW-1:0];
   endfunction

   always_comb begin
      end_a = edge_end(side.base_a, side.neg_a, div_a);
      end_b = edge_end(side.base_b, side.neg_b, div_b);
      lo    = (end_a > end_b) ? end_b : end_a;
      hi    = (end_a > end_b) ? end_a : end_b;
      drawn_in = side.drawn;
      row_y_in = side.drawn ? side.row_y : '0;
      left_in  = side.drawn ? clip_x(lo) : '0;
      right_in = side.drawn ? clip_x(hi) : '0;
   end

   // Result register; it holds while the consumer stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         drawn_ff <= drawn_in;
         row_y_ff <= row_y_in;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign out_valid  = valid_ff;
   assign row_inside = drawn_ff;
   assign row_y      = row_y_ff;
   assign span_left  = left_ff;
   assign span_right = right_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/triangle_scanline_span.sv =====
// Top level of the triangle scanline span pipeline.
`timescale 1ns / 1ps
`default_nettype none
// One request per cycle gives one span per cycle while the consumer does not
// stall. Each request passes through a sort stage, a multiply stage, twelve
// divider stages (one quotient bit each, both edges in parallel) and a result
// stage. The pipeline moves as one whenever the result register is empty or
// its transfer completes, so a stalled consumer holds every stage in place.
module triangle_scanline_span (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tss_pkg::coord_type req_ax,
   input  wire tss_pkg::coord_type req_ay,
   input  wire tss_pkg::coord_type req_bx,
   input  wire tss_pkg::coord_type req_by_coord,
   input  wire tss_pkg::coord_type req_cx,
   input  wire tss_pkg::coord_type req_cy,
   input  wire tss_pkg::coord_type req_row_offset,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_row_inside,
   output tss_pkg::coord_type     rsp_row_y,
   output tss_pkg::coord_type     rsp_span_left,
   output tss_pkg::coord_type     rsp_span_right
);
   import tss_pkg::*;

   logic     enable;
   logic     s1_valid, s2_valid, s3_valid;
   lane_type s1_lane_a, s1_lane_b;
   side_type s1_side, s2_side, s3_side;
   div_type  s2_div_a, s2_div_b, s3_div_a, s3_div_b;

   // Advance when the result register is free or being taken.
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   tss_setup u_setup (
      .clock, .reset, .enable,
      .in_valid(req_valid),
      .ax(req_ax), .ay(req_ay), .bx(req_bx), .by_coord(req_by_coord),
      .cx(req_cx), .cy(req_cy), .row_offset(req_row_offset),
      .out_valid(s1_valid), .lane_a(s1_lane_a), .lane_b(s1_lane_b), .side(s1_side)
   );

   tss_mul u_mul (
      .clock, .reset, .enable,
      .in_valid(s1_valid), .lane_a(s1_lane_a), .lane_b(s1_lane_b), .side_i(s1_side),
      .out_valid(s2_valid), .div_a(s2_div_a), .div_b(s2_div_b), .side_o(s2_side)
   );

   tss_div u_div (
      .clock, .reset, .enable,
      .in_valid(s2_valid), .div_a_i(s2_div_a), .div_b_i(s2_div_b), .side_i(s2_side),
      .out_valid(s3_valid), .div_a_o(s3_div_a), .div_b_o(s3_div_b), .side_o(s3_side)
   );

   tss_finish u_finish (
      .clock, .reset, .enable,
      .in_valid(s3_valid), .div_a(s3_div_a), .div_b(s3_div_b), .side(s3_side),
      .out_valid(rsp_valid), .row_inside(rsp_row_inside), .row_y(rsp_row_y),
      .span_left(rsp_span_left), .span_right(rsp_span_right)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/tss_checker.sv =====
// Port-level assertions for the triangle scanline span pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tss_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_row_inside,
   input wire logic [11:0] rsp_row_y,
   input wire logic [11:0] rsp_span_left,
   input wire logic [11:0] rsp_span_right
);

   // A pending result is not withdrawn before its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // With the result register empty the pipeline must take requests.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("requests refused with an empty result register");

   // Rows outside the triangle report all zeros.
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_row_inside |->
         rsp_row_y == 12'd0 && rsp_span_left == 12'd0 && rsp_span_right == 12'd0)
      else $error("outside row with nonzero fields");

   // Span ends come out ordered.
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_inside |-> rsp_span_left <= rsp_span_right)
      else $error("span ends out of order");

endmodule

bind triangle_scanline_span tss_checker u_tss_checker (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready, .rsp_row_inside,
   .rsp_row_y, .rsp_span_left, .rsp_span_right
);
`default_nettype wire

// ===== bench/triangle_scanline_span_tb.sv =====
// Self-checking testbench for the triangle scanline span pipeline.
`timescale 1ns / 1ps
module triangle_scanline_span_tb;
   import tss_pkg::*;

   typedef struct packed {
      coord_type ax, ay, bx, by_coord, cx, cy, row_offset;
   } query_type;

   typedef struct packed {
      logic      drawn;
      coord_type row_y, left, right;
   } span_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   coord_type req_ax = '0, req_ay = '0, req_bx = '0, req_by_coord = '0;
   coord_type req_cx = '0, req_cy = '0, req_row_offset = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_row_inside;
   coord_type rsp_row_y, rsp_span_left, rsp_span_right;

   query_type pending_queries[$];
   span_type  expected_spans[$];
   int        mismatch_count = 0;
   int        span_count = 0;
   int        drawn_count = 0;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   bit        hold_sender = 1'b0;

   triangle_scanline_span dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Floor of base + d*num/den, never below zero.
   function automatic longint span_end(longint base, longint d, longint num, longint den);
      longint total;
      total = base * den + d * num;
      if (total < 0) total = 0;
      return total / den;
   endfunction

   function automatic coord_type clip_x(longint v);
      if (v < 0) v = 0;
      if (v > ImageSize - 1) v = ImageSize - 1;
      return coord_type'(v);
   endfunction

   // Expected span for one query.
   function automatic span_type compute_span(query_type q);
      longint vx[3], vy[3], t, i, h, h_up, a, b;
      span_type s;
      vx[0] = q.ax; vy[0] = q.ay; vx[1] = q.bx; vy[1] = q.by_coord;
      vx[2] = q.cx; vy[2] = q.cy; i = q.row_offset;
      s = '0;
      // Three compare-and-swap stages, swapping only on strictly greater.
      if (vy[0] > vy[1]) begin
         t = vx[0]; vx[0] = vx[1]; vx[1] = t; t = vy[0]; vy[0] = vy[1]; vy[1] = t;
      end
      if (vy[0] > vy[2]) begin
         t = vx[0]; vx[0] = vx[2]; vx[2] = t; t = vy[0]; vy[0] = vy[2]; vy[2] = t;
      end
      if (vy[1] > vy[2]) begin
         t = vx[1]; vx[1] = vx[2]; vx[2] = t; t = vy[1]; vy[1] = vy[2]; vy[2] = t;
      end
      h = vy[2] - vy[0];
      if (i >= h || vy[0] + i >= ImageSize) return s;
      h_up = vy[1] - vy[0];
      a = span_end(vx[0], vx[2] - vx[0], i, h);
      if (i > h_up || h_up == 0)
         b = span_end(vx[1], vx[2] - vx[1], i - h_up, vy[2] - vy[1]);
      else
         b = span_end(vx[0], vx[1] - vx[0], i, h_up);
      if (a > b) begin
         t = a; a = b; b = t;
      end
      s.drawn  = 1'b1;
      s.row_y  = coord_type'(vy[0] + i);
      s.left   = clip_x(a);
      s.right  = clip_x(b);
      return s;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH span %0d %s: got %0d, expected %0d", span_count, what, got, want);
      mismatch_count++;
   endtask

   // Driver: presents the next query and holds it until its transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_spans.push_back(compute_span(pending_queries.pop_front()));
         end
         if (!(req_valid && !req_ready)) begin
            if (pending_queries.size() > 0 && !hold_sender
                && $urandom_range(99) >= send_idle_pct) begin
               // The head may already have moved on; peek after the pop above.
               req_valid      <= 1'b1;
               req_ax         <= pending_queries[0].ax;
               req_ay         <= pending_queries[0].ay;
               req_bx         <= pending_queries[0].bx;
               req_by_coord   <= pending_queries[0].by_coord;
               req_cx         <= pending_queries[0].cx;
               req_cy         <= pending_queries[0].cy;
               req_row_offset <= pending_queries[0].row_offset;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result transfer against the oldest expectation.
   always @(posedge clock) begin
      span_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_spans.size() == 0) begin
               report_mismatch("unexpected transfer", 1, 0);
            end else begin
               want = expected_spans.pop_front();
               if (rsp_row_inside !== want.drawn)
                  report_mismatch("row_inside", rsp_row_inside, want.drawn);
               if (rsp_row_y !== want.row_y) report_mismatch("row_y", rsp_row_y, want.row_y);
               if (rsp_span_left !== want.left)
                  report_mismatch("span_left", rsp_span_left, want.left);
               if (rsp_span_right !== want.right)
                  report_mismatch("span_right", rsp_span_right, want.right);
               if (want.drawn) drawn_count++;
            end
            span_count++;
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic query_type random_query();
      query_type q;
      q.ax         = coord_type'($urandom);
      q.ay         = coord_type'($urandom);
      q.bx         = coord_type'($urandom);
      q.by_coord   = coord_type'($urandom);
      q.cx         = coord_type'($urandom);
      q.cy         = coord_type'($urandom);
      q.row_offset = coord_type'($urandom);
      // Mostly keep the row within the triangle so spans get drawn.
      if ($urandom_range(3) != 0) begin
         coord_type lo, hi;
         lo = q.ay; hi = q.ay;
         if (q.by_coord < lo) lo = q.by_coord;
         if (q.cy < lo) lo = q.cy;
         if (q.by_coord > hi) hi = q.by_coord;
         if (q.cy > hi) hi = q.cy;
         if (hi > lo) q.row_offset = coord_type'($urandom_range(hi - lo - 1));
         if ($urandom_range(4) == 0) q.row_offset = coord_type'(hi - lo);
      end
      return q;
   endfunction

   task automatic add_query(int ax, int ay, int bx, int by, int cx, int cy, int i);
      query_type q;
      q.ax = coord_type'(ax); q.ay = coord_type'(ay); q.bx = coord_type'(bx);
      q.by_coord = coord_type'(by); q.cx = coord_type'(cx); q.cy = coord_type'(cy);
      q.row_offset = coord_type'(i);
      pending_queries.push_back(q);
   endtask

   task automatic wait_drained();
      while (pending_queries.size() > 0 || req_valid || expected_spans.size() > 0)
         @(posedge clock);
   endtask

   // Stimulus and phase control.
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // Directed: flat triangles, half-open bottom row, segment boundaries, extremes.
      add_query(0, 5, 100, 5, 4095, 5, 0);
      add_query(0, 0, 10, 10, 20, 20, 20);
      add_query(0, 0, 10, 10, 20, 20, 19);
      add_query(0, 0, 10, 10, 20, 20, 10);
      add_query(0, 0, 4095, 0, 2000, 4095, 0);
      add_query(0, 0, 4095, 0, 2000, 4095, 4094);
      add_query(4095, 4095, 0, 0, 2048, 100, 99);
      add_query(100, 10, 50, 40, 10, 10, 0);
      add_query(10, 10, 100, 10, 50, 40, 29);
      add_query(4095, 0, 0, 4095, 4095, 4095, 4095);
      add_query(0, 4000, 4095, 4095, 0, 4095, 94);
      add_query(3, 7, 9, 2, 1, 30, 5);
      add_query(3, 7, 9, 2, 1, 30, 6);
      add_query(0, 0, 0, 0, 0, 0, 0);
      add_query(4095, 4095, 4095, 4095, 4095, 4095, 4095);
      add_query(1, 0, 4094, 4095, 2047, 2048, 2048);
      for (int k = 0; k < 175; k++) pending_queries.push_back(random_query());
      wait_drained();
      // Pause the sender once every result is back, then continue.
      hold_sender = 1'b1;
      repeat (20) @(posedge clock);
      hold_sender = 1'b0;
      send_idle_pct = 74;
      for (int k = 0; k < 175; k++) pending_queries.push_back(random_query());
      wait_drained();
      send_idle_pct = 0; recv_stall_pct = 74;
      for (int k = 0; k < 175; k++) pending_queries.push_back(random_query());
      wait_drained();
      send_idle_pct = 7; recv_stall_pct = 7;
      for (int k = 0; k < 175; k++) pending_queries.push_back(random_query());
      wait_drained();
      repeat (30) @(posedge clock);
      $display("Checked %0d spans (%0d inside rows) over four idling phases.",
               span_count, drawn_count);
      if (mismatch_count == 0 && expected_spans.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end
endmodule

// ===== triangle_scanline_span.f =====
hw/rtl/tss_pkg.sv
hw/rtl/tss_setup.sv
hw/rtl/tss_mul.sv
hw/rtl/tss_div.sv
hw/rtl/tss_finish.sv
hw/rtl/triangle_scanline_span.sv
hw/rtl/tss_checker.sv
bench/triangle_scanline_span_tb.sv
